/* hw/rtl/pcbb_pkg.sv */
// Shared types, constants and helpers for the pixel class bounding box block.
`default_nettype none

package pcbb_pkg;

  localparam int unsigned POS_W  = 10;  // pixel coordinate width
  localparam int unsigned DIM_W  = 11;  // frame size, box corner and span width
  localparam int unsigned ARGB_W = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned NCLASS = 3;

  localparam logic [DIM_W-1:0] MAX_DIM = 11'd1024;

  localparam logic [7:0] ALPHA_MIN = 8'd10;
  localparam logic [7:0] DARK_MAX  = 8'd5;
  localparam logic [7:0] GREY_LO   = 8'd130;
  localparam logic [7:0] GREY_HI   = 8'd140;

  // most negative span, -1024 in 11-bit two's complement
  localparam logic [DIM_W-1:0] SPAN_NEG_LIMIT = 11'h400;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_GREY_ENABLE  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLS_VISIBLE = 2'd0,
    CLS_DARK    = 2'd1,
    CLS_GREY    = 2'd2
  } cls_t;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] min_x;
    logic [POS_W-1:0] max_x;
    logic [POS_W-1:0] min_y;
    logic [POS_W-1:0] max_y;
  } bnd_t;

  function automatic logic in_grey(input logic [7:0] v);
    in_grey = (v > GREY_LO) && (v < GREY_HI);
  endfunction

  // fold one pixel into a class's bounds
  function automatic bnd_t track(input bnd_t b, input logic [POS_W-1:0] x,
                                 input logic [POS_W-1:0] y);
    bnd_t n;
    n.hit   = 1'b1;
    n.min_x = (!b.hit || x < b.min_x) ? x : b.min_x;
    n.max_x = (!b.hit || x > b.max_x) ? x : b.max_x;
    n.min_y = (!b.hit || y < b.min_y) ? y : b.min_y;
    n.max_y = (!b.hit || y > b.max_y) ? y : b.max_y;
    track = n;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/pixel_class_bounding_boxes.sv */
// Top level: per-class bounding box tracking over a pixel stream.
`default_nettype none

// Takes one pixel per clock, in any order within a frame, and tracks the min/max
// column and row of three classes (visible, dark, grey) in flip-flops. The
// pixel flagged frame_end is folded in, then the three box sets are copied to
// a snapshot and the live bounds restart for the next frame. The snapshot
// drains through the output register as two results (visible, dark) or three
// (plus grey when grey_enable is set), one per cycle while out_ready is high.
// Ordinary pixels keep flowing at one per clock during that drain; a pixel
// carrying frame_end waits until the previous frame's last result is leaving
// the snapshot, so back-to-back frame ends are taken one per snapshot drain.
// At the earliest, the first result passes from the frame_end transaction
// through the snapshot and then the output register to the outputs.
// The configuration port is always ready; write it only while the block is idle.
module pixel_class_bounding_boxes
  import pcbb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [DIM_W-1:0]      cfg_data,

  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [POS_W-1:0]      in_pos_x,
  input  wire logic [POS_W-1:0]      in_pos_y,
  input  wire logic [ARGB_W-1:0]     in_pixel_argb,
  input  wire logic                  in_frame_end,

  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_region_class,
  output logic [DIM_W-1:0]           out_box_left,
  output logic [DIM_W-1:0]           out_box_top,
  output logic signed [DIM_W-1:0]    out_span_x,
  output logic signed [DIM_W-1:0]    out_span_y,
  output logic                       out_last_result
);

  // configuration
  logic [DIM_W-1:0] frame_width_r;
  logic [DIM_W-1:0] frame_height_r;
  logic             grey_enable_r;

  // live bounds and the end-of-frame snapshot
  bnd_t bnd_r  [NCLASS];
  bnd_t snap_r [NCLASS];
  bnd_t trk_nxt [NCLASS];
  logic snap_busy_r;
  cls_t snap_cls_r;

  // output register
  logic             out_valid_r;
  cls_t             out_cls_r;
  logic [DIM_W-1:0] out_left_r;
  logic [DIM_W-1:0] out_top_r;
  logic [DIM_W-1:0] out_sx_r;
  logic [DIM_W-1:0] out_sy_r;
  logic             out_last_r;

  logic       in_accept;
  logic [7:0] a_ch, r_ch, g_ch, b_ch;
  logic [NCLASS-1:0] match;

  bnd_t             sel;
  logic [DIM_W-1:0] left_nxt, top_nxt, sx_nxt, sy_nxt;
  logic             last_nxt;
  logic             load;

  function automatic logic [DIM_W-1:0] neg_span(input logic [DIM_W-1:0] d);
    neg_span = (d > MAX_DIM) ? SPAN_NEG_LIMIT : (~d + 1'b1);
  endfunction

  assign cfg_ready = 1'b1;

  // a frame end needs the snapshot free, or its last result leaving now
  assign in_ready  = !in_frame_end || !snap_busy_r || (load && last_nxt);
  assign in_accept = in_valid && in_ready;

  assign a_ch = in_pixel_argb[31:24];
  assign r_ch = in_pixel_argb[23:16];
  assign g_ch = in_pixel_argb[15:8];
  assign b_ch = in_pixel_argb[7:0];

  always_comb begin
    match[CLS_VISIBLE] = a_ch > ALPHA_MIN;
    match[CLS_DARK]    = match[CLS_VISIBLE] &&
                         (r_ch < DARK_MAX) && (g_ch < DARK_MAX) && (b_ch < DARK_MAX);
    match[CLS_GREY]    = match[CLS_VISIBLE] &&
                         in_grey(r_ch) && in_grey(g_ch) && in_grey(b_ch);
    for (int c = 0; c < NCLASS; c++) begin
      trk_nxt[c] = match[c] ? track(bnd_r[c], in_pos_x, in_pos_y) : bnd_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= MAX_DIM;
      frame_height_r <= MAX_DIM;
      grey_enable_r  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        REG_GREY_ENABLE:  grey_enable_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCLASS; c++) begin
        bnd_r[c].hit <= 1'b0;
      end
    end else if (in_accept) begin
      for (int c = 0; c < NCLASS; c++) begin
        bnd_r[c].min_x <= trk_nxt[c].min_x;
        bnd_r[c].max_x <= trk_nxt[c].max_x;
        bnd_r[c].min_y <= trk_nxt[c].min_y;
        bnd_r[c].max_y <= trk_nxt[c].max_y;
        bnd_r[c].hit   <= trk_nxt[c].hit && !in_frame_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_frame_end) begin
      for (int c = 0; c < NCLASS; c++) begin
        snap_r[c] <= trk_nxt[c];
      end
    end
  end

  // result for the class currently selected in the snapshot
  always_comb begin
    case (snap_cls_r)
      CLS_VISIBLE: sel = snap_r[CLS_VISIBLE];
      CLS_DARK:    sel = snap_r[CLS_DARK];
      default:     sel = snap_r[CLS_GREY];
    endcase

    if (sel.hit) begin
      left_nxt = {1'b0, sel.min_x};
      top_nxt  = {1'b0, sel.min_y};
      sx_nxt   = {1'b0, sel.max_x - sel.min_x};
      sy_nxt   = {1'b0, sel.max_y - sel.min_y};
    end else if (snap_cls_r == CLS_GREY) begin
      left_nxt = '0;
      top_nxt  = frame_height_r;
      sx_nxt   = '0;
      sy_nxt   = '0;
    end else begin
      left_nxt = frame_width_r;
      top_nxt  = frame_height_r;
      sx_nxt   = neg_span(frame_width_r);
      sy_nxt   = neg_span(frame_height_r);
    end

    last_nxt = (snap_cls_r == CLS_GREY) || (snap_cls_r == CLS_DARK && !grey_enable_r);
  end

  assign load = snap_busy_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_busy_r <= 1'b0;
      snap_cls_r  <= CLS_VISIBLE;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept && in_frame_end) begin
        snap_busy_r <= 1'b1;
        snap_cls_r  <= CLS_VISIBLE;
      end else if (load) begin
        if (last_nxt) begin
          snap_busy_r <= 1'b0;
        end else begin
          snap_cls_r <= (snap_cls_r == CLS_VISIBLE) ? CLS_DARK : CLS_GREY;
        end
      end

      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_cls_r  <= snap_cls_r;
      out_left_r <= left_nxt;
      out_top_r  <= top_nxt;
      out_sx_r   <= sx_nxt;
      out_sy_r   <= sy_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_region_class = out_cls_r;
  assign out_box_left     = out_left_r;
  assign out_box_top      = out_top_r;
  assign out_span_x       = out_sx_r;
  assign out_span_y       = out_sy_r;
  assign out_last_result  = out_last_r;

endmodule

`default_nettype wire

/* test/tb.sv */
// Testbench for pixel_class_bounding_boxes: per-class box prediction and result checks.
`default_nettype none

module tb;
  import pcbb_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int SETTLE      = 8;
  localparam int PRINT_CAP   = 50;

  typedef struct {
    cls_t                    cls;
    logic [DIM_W-1:0]        left;
    logic [DIM_W-1:0]        top;
    logic signed [DIM_W-1:0] span_x;
    logic signed [DIM_W-1:0] span_y;
    logic                    last;
  } box_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [DIM_W-1:0]           cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [POS_W-1:0]           in_pos_x = '0;
  logic [POS_W-1:0]           in_pos_y = '0;
  logic [ARGB_W-1:0]          in_pixel_argb = '0;
  logic                       in_frame_end = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [1:0]                 out_region_class;
  logic [DIM_W-1:0]           out_box_left;
  logic [DIM_W-1:0]           out_box_top;
  logic signed [DIM_W-1:0]    out_span_x;
  logic signed [DIM_W-1:0]    out_span_y;
  logic                       out_last_result;

  pixel_class_bounding_boxes dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_pixel_argb(in_pixel_argb), .in_frame_end(in_frame_end),
    .out_valid(out_valid), .out_ready(out_ready), .out_region_class(out_region_class),
    .out_box_left(out_box_left), .out_box_top(out_box_top), .out_span_x(out_span_x),
    .out_span_y(out_span_y), .out_last_result(out_last_result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the block: live bounds per class plus register copies
  logic             cls_hit [NCLASS];
  logic [POS_W-1:0] lo_x [NCLASS];
  logic [POS_W-1:0] hi_x [NCLASS];
  logic [POS_W-1:0] lo_y [NCLASS];
  logic [POS_W-1:0] hi_y [NCLASS];
  logic [DIM_W-1:0] cur_width;
  logic [DIM_W-1:0] cur_height;
  logic             grey_on;

  box_result_t pending_boxes [$];
  box_result_t want_box;
  int          mismatches = 0;
  int          stuck_cycles = 0;
  int          burst_left = 0;
  int          ready_mode = 0;
  int          ready_phase = 0;

  task automatic note_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic logic [DIM_W-1:0] clamp_span(input int s);
    if (s < -1024) s = -1024;
    if (s > 1023) s = 1023;
    return s[DIM_W-1:0];
  endfunction

  function automatic box_result_t class_box(input int c, input logic last);
    box_result_t bx;
    int sx, sy;
    bx.cls = cls_t'(c);
    bx.last = last;
    if (cls_hit[c]) begin
      bx.left = {1'b0, lo_x[c]};
      bx.top = {1'b0, lo_y[c]};
      sx = int'(hi_x[c]) - int'(lo_x[c]);
      sy = int'(hi_y[c]) - int'(lo_y[c]);
    end else if (c == CLS_GREY) begin
      bx.left = '0;
      bx.top = cur_height;
      sx = 0;
      sy = 0;
    end else begin
      bx.left = cur_width;
      bx.top = cur_height;
      sx = -int'(cur_width);
      sy = -int'(cur_height);
    end
    bx.span_x = clamp_span(sx);
    bx.span_y = clamp_span(sy);
    return bx;
  endfunction

  // append one expected box at the tail of the queue
  task automatic queue_box(input box_result_t bx);
    pending_boxes = {pending_boxes, bx};
  endtask

  // fold an accepted pixel into the shadow bounds, queue the boxes on frame end
  task automatic absorb_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                              input logic [ARGB_W-1:0] argb, input logic fe);
    logic [7:0] a, r, g, b;
    logic       member [NCLASS];
    a = argb[31:24];
    r = argb[23:16];
    g = argb[15:8];
    b = argb[7:0];
    member[CLS_VISIBLE] = a > ALPHA_MIN;
    member[CLS_DARK] = member[CLS_VISIBLE] && r < DARK_MAX && g < DARK_MAX && b < DARK_MAX;
    member[CLS_GREY] = member[CLS_VISIBLE] && r > GREY_LO && r < GREY_HI &&
                       g > GREY_LO && g < GREY_HI && b > GREY_LO && b < GREY_HI;
    for (int c = 0; c < NCLASS; c++) begin
      if (member[c]) begin
        if (!cls_hit[c] || x < lo_x[c]) lo_x[c] = x;
        if (!cls_hit[c] || x > hi_x[c]) hi_x[c] = x;
        if (!cls_hit[c] || y < lo_y[c]) lo_y[c] = y;
        if (!cls_hit[c] || y > hi_y[c]) hi_y[c] = y;
        cls_hit[c] = 1'b1;
      end
    end
    if (fe) begin
      queue_box(class_box(CLS_VISIBLE, 1'b0));
      queue_box(class_box(CLS_DARK, !grey_on));
      if (grey_on) queue_box(class_box(CLS_GREY, 1'b1));
      for (int c = 0; c < NCLASS; c++) cls_hit[c] = 1'b0;
    end
  endtask

  task automatic send_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                            input logic [ARGB_W-1:0] argb, input logic fe);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pixel_argb <= argb;
    in_frame_end <= fe;
    do @(posedge clk); while (!in_ready);
    absorb_pixel(x, y, argb, fe);
  endtask

  // hold the sender off until every queued box has come out, then let the block settle
  task automatic wait_for_boxes(input int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_WIDTH:  cur_width = val;
      REG_FRAME_HEIGHT: cur_height = val;
      REG_GREY_ENABLE:  grey_on = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] channel_edge();
    case ($urandom_range(0, 7))
      0: return 8'd4;
      1: return 8'd5;
      2: return 8'd130;
      3: return 8'd131;
      4: return 8'd139;
      5: return 8'd140;
      6: return 8'd0;
      default: return 8'd255;
    endcase
  endfunction

  function automatic logic [ARGB_W-1:0] random_argb();
    logic [7:0] a, r, g, b;
    int kind;
    kind = $urandom_range(0, 9);
    a = 8'($urandom_range(11, 255));
    r = 8'($urandom());
    g = 8'($urandom());
    b = 8'($urandom());
    case (kind)
      0, 1: return $urandom();
      2: begin
        r = 8'($urandom_range(0, 4));
        g = 8'($urandom_range(0, 4));
        b = 8'($urandom_range(0, 4));
      end
      3, 4: begin
        r = 8'($urandom_range(131, 139));
        g = 8'($urandom_range(131, 139));
        b = 8'($urandom_range(131, 139));
      end
      5: a = 8'($urandom_range(0, 10));
      6, 7: begin
        a = ($urandom_range(0, 1) == 1) ? ALPHA_MIN : ALPHA_MIN + 8'd1;
        r = channel_edge();
        g = channel_edge();
        b = channel_edge();
      end
      default: ;
    endcase
    return {a, r, g, b};
  endfunction

  // one frame of random pixels; each coordinate is drawn in the frame half the time
  task automatic send_frame(input int n);
    int reach;
    logic [POS_W-1:0] x, y;
    for (int i = 0; i < n; i++) begin
      reach = (cur_width > 1024) ? 1024 : int'(cur_width);
      x = ($urandom_range(0, 1) == 1) ? POS_W'($urandom_range(0, reach - 1))
                                      : POS_W'($urandom_range(0, 1023));
      reach = (cur_height > 1024) ? 1024 : int'(cur_height);
      y = ($urandom_range(0, 1) == 1) ? POS_W'($urandom_range(0, reach - 1))
                                      : POS_W'($urandom_range(0, 1023));
      send_pixel(x, y, random_argb(), i == n - 1);
    end
  endtask

  task automatic test_directed_classes();
    send_pixel(10'd0, 10'd0, 32'h00000000, 1'b1);        // empty frame, reset defaults
    send_pixel(10'd0, 10'd0, 32'hFF000000, 1'b0);
    send_pixel(10'd1023, 10'd1023, 32'h0B868686, 1'b0);  // lowest visible alpha, grey
    send_pixel(10'd500, 10'd7, 32'h0A000000, 1'b0);      // alpha at threshold: invisible
    send_pixel(10'd3, 10'd900, 32'hFF040404, 1'b0);
    send_pixel(10'd700, 10'd2, 32'hFF050505, 1'b0);      // just too bright for dark
    send_pixel(10'd9, 10'd9, 32'hFF838383, 1'b0);
    send_pixel(10'd800, 10'd800, 32'hFF8B8B8B, 1'b0);
    send_pixel(10'd10, 10'd10, 32'hFF828282, 1'b0);      // grey bounds are exclusive
    send_pixel(10'd11, 10'd11, 32'hFF8C8C8C, 1'b0);
    send_pixel(10'd12, 10'd12, 32'hFF86868C, 1'b0);
    send_pixel(10'd13, 10'd13, 32'hFF000400, 1'b0);
    send_pixel(10'd14, 10'd14, 32'hFF000005, 1'b0);
    send_pixel(10'd15, 10'd15, 32'hFFFFFFFF, 1'b0);
    send_pixel(10'd1023, 10'd0, 32'h00000000, 1'b1);
    send_pixel(10'd512, 10'd256, 32'h80868686, 1'b1);    // single grey pixel: zero visible and grey spans
    send_pixel(10'd1, 10'd2, 32'hFFFFFFFF, 1'b1);        // visible only
  endtask

  task automatic test_register_extremes();
    wait_for_boxes(SETTLE);
    write_reg(REG_GREY_ENABLE, 11'd0);
    write_reg(REG_FRAME_WIDTH, 11'd1);
    write_reg(REG_FRAME_HEIGHT, 11'd1);
    send_pixel(10'd5, 10'd5, 32'h00FFFFFF, 1'b1);
    send_pixel(10'd0, 10'd0, 32'hFF000000, 1'b1);
    send_frame(4);
    wait_for_boxes(SETTLE);
    // frame sizes past 1024 push the empty-class spans into saturation
    write_reg(REG_FRAME_WIDTH, 11'd2047);
    write_reg(REG_FRAME_HEIGHT, 11'd1025);
    send_pixel(10'd0, 10'd0, 32'h05000000, 1'b1);
    send_pixel(10'd1023, 10'd1023, 32'hFF868686, 1'b1);
    send_frame(3);
    wait_for_boxes(SETTLE);
    write_reg(REG_GREY_ENABLE, 11'd1);
    write_reg(REG_FRAME_WIDTH, 11'd1024);
    write_reg(REG_FRAME_HEIGHT, 11'd1024);
    send_pixel(10'd0, 10'd0, 32'h0A868686, 1'b1);
    send_frame(2);
  endtask

  task automatic test_random_frames();
    int sent;
    int len;
    for (int phase = 0; phase < 6; phase++) begin
      wait_for_boxes(SETTLE);
      case ($urandom_range(0, 4))
        0: write_reg(REG_FRAME_WIDTH, 11'd1);
        1: write_reg(REG_FRAME_WIDTH, 11'd2047);
        2: write_reg(REG_FRAME_WIDTH, 11'd1024);
        default: write_reg(REG_FRAME_WIDTH, DIM_W'($urandom_range(1, 1024)));
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(REG_FRAME_HEIGHT, 11'd1);
        1: write_reg(REG_FRAME_HEIGHT, 11'd2047);
        2: write_reg(REG_FRAME_HEIGHT, 11'd1024);
        default: write_reg(REG_FRAME_HEIGHT, DIM_W'($urandom_range(1, 1024)));
      endcase
      write_reg(REG_GREY_ENABLE, DIM_W'($urandom_range(0, 1)));
      sent = 0;
      while (sent < 55) begin
        len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 10);
        send_frame(len);
        sent += len;
        if ($urandom_range(0, 9) == 0) wait_for_boxes(0);
      end
    end
  endtask

  // receiver: ready pattern switches between steady, random and long-stall stretches
  always @(negedge clk) begin
    if (ready_phase == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_phase = $urandom_range(10, 60);
    end
    ready_phase--;
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 1) == 0);
      default: out_ready <= (ready_phase % 7) < 2;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_boxes.size() == 0) begin
        note_mismatch("unexpected result, class", int'(out_region_class), -1);
      end else begin
        want_box = pending_boxes.pop_front();
        if (out_region_class !== want_box.cls)
          note_mismatch("region_class", int'(out_region_class), int'(want_box.cls));
        if (out_box_left !== want_box.left)
          note_mismatch("box_left", int'(out_box_left), int'(want_box.left));
        if (out_box_top !== want_box.top)
          note_mismatch("box_top", int'(out_box_top), int'(want_box.top));
        if (out_span_x !== want_box.span_x)
          note_mismatch("span_x", int'(out_span_x), int'(want_box.span_x));
        if (out_span_y !== want_box.span_y)
          note_mismatch("span_y", int'(out_span_y), int'(want_box.span_y));
        if (out_last_result !== want_box.last)
          note_mismatch("last_result", int'(out_last_result), int'(want_box.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("pixel_class_bounding_boxes verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    cur_width = MAX_DIM;
    cur_height = MAX_DIM;
    grey_on = 1'b1;
    for (int c = 0; c < NCLASS; c++) cls_hit[c] = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_classes();
    test_register_extremes();
    test_random_frames();
    wait_for_boxes(10);
    if (mismatches == 0) begin
      $display("pixel_class_bounding_boxes verification clean");
    end else begin
      $display("pixel_class_bounding_boxes verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/pcbb_pkg.sv
hw/rtl/pixel_class_bounding_boxes.sv
test/tb.sv
